// ===== design/pfc_pkg.sv =====
`timescale 1ns / 1ps

package pfc_pkg;

    // Grid geometry
    localparam int GRID_SIDE  = 5;
    localparam int GRID_CELLS = 25;
    localparam int IDX_W      = 5;   // letter index 0..25
    localparam int POS_W      = 3;   // row or column 0..4
    localparam int ADDR_W     = 5;   // cell address 0..24
    localparam int ALPHABET   = 26;

    // Letter indices and ASCII base
    localparam logic [IDX_W-1:0] LETTER_I   = 5'd8;
    localparam logic [IDX_W-1:0] LETTER_J   = 5'd9;
    localparam logic [IDX_W-1:0] LETTER_X   = 5'd23;
    localparam logic [IDX_W-1:0] LETTER_Z   = 5'd25;
    localparam logic [6:0]       ASCII_A    = 7'h61;
    localparam logic [POS_W-1:0] POS_LAST   = 3'd4;
    localparam logic [ADDR_W-1:0] ADDR_LAST = 5'd24;
    localparam logic [ADDR_W-1:0] CELLS_FULL = 5'd25;

    // Operation codes
    localparam logic [1:0] OP_KEY_BYTE  = 2'd0;
    localparam logic [1:0] OP_KEY_END   = 2'd1;
    localparam logic [1:0] OP_TEXT_BYTE = 2'd2;
    localparam logic [1:0] OP_TEXT_END  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_SCAN,
        ST_SCAN_END,
        ST_READ1,
        ST_READ2,
        ST_READ3,
        ST_EMIT1,
        ST_EMIT2
    } state_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } letter_t;

    // Map a raw byte to a letter index, folding j onto i
    function automatic letter_t letter_index(input logic [7:0] b);
        letter_t    res;
        logic [7:0] tmp;
        res.valid = 1'b0;
        tmp       = 8'h00;
        if (b >= 8'h41 && b <= 8'h5A) begin
            tmp       = b - 8'h41;
            res.valid = 1'b1;
        end else if (b >= 8'h61 && b <= 8'h7A) begin
            tmp       = b - 8'h61;
            res.valid = 1'b1;
        end
        res.idx = tmp[IDX_W-1:0];
        if (res.idx == LETTER_J) begin
            res.idx = LETTER_I;
        end
        return res;
    endfunction

    // Move one place forward or backward around a row or column
    function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] p,
                                                  input logic dec);
        logic [POS_W-1:0] res;
        if (dec) begin
            res = (p == '0) ? POS_LAST : p - 3'd1;
        end else begin
            res = (p == POS_LAST) ? '0 : p + 3'd1;
        end
        return res;
    endfunction

    // Row-major cell address: row * 5 + col
    function automatic logic [ADDR_W-1:0] grid_addr(input logic [POS_W-1:0] row,
                                                   input logic [POS_W-1:0] col);
        logic [ADDR_W-1:0] r;
        r = {2'b00, row};
        return (r << 2) + r + {2'b00, col};
    endfunction

endpackage

// ===== design/pfc_ram.sv =====
`timescale 1ns / 1ps

module pfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/playfair_digraph_cipher_core.sv =====
`timescale 1ns / 1ps

// Playfair cipher engine on a 5x5 letter grid held in a small RAM.
// Input channel (in_valid / in_stall): operation plus data_byte. Key bytes
// build the grid, key end fills the rest of the grid, text bytes are paired
// and each pair gives two result transactions; text end pads a lone letter.
// Output channel (out_valid / out_stall): letter plus last_of_run, which
// marks the second letter of a pair.
// cfg_write_en / cfg_write_data set decrypt_mode; write it only when idle.
// A key byte or a first text letter is taken without leaving idle. Key end
// walks the alphabet once through the grid write port. A pair scans all 25
// cells through the single RAM read port into two comparators, then reads
// two cells and loads the output register twice, first letter then second,
// in_stall high throughout.
// A stalled receiver holds the result in the output register; the block
// waits in its emit step, and takes the next input once the last letter
// of a pair is loaded. Reset clears the key state, the pending letter and
// the mode; grid contents stay undefined until written by a key.

module playfair_digraph_cipher_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic       cfg_write_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] letter,
    output logic       last_of_run
);

    localparam int IW = pfc_pkg::IDX_W;
    localparam int PW = pfc_pkg::POS_W;
    localparam int AW = pfc_pkg::ADDR_W;

    // Control state
    pfc_pkg::state_t             state_reg, state_next;
    logic                        decrypt_mode_reg;
    logic [pfc_pkg::ALPHABET-1:0] used_reg, used_next;
    logic [AW-1:0]               fill_count_reg, fill_count_next;
    logic                        pending_valid_reg, pending_valid_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        look_valid_reg, look_valid_next;
    logic                        found_a_reg, found_a_next;
    logic                        found_b_reg, found_b_next;

    // Payload state
    logic [IW-1:0] pending_letter_reg, pending_letter_next;
    logic [IW-1:0] pair_b_reg, pair_b_next;
    logic [IW-1:0] fill_letter_reg, fill_letter_next;
    logic [AW-1:0] scan_addr_reg, scan_addr_next;
    logic [PW-1:0] scan_row_reg, scan_row_next;
    logic [PW-1:0] scan_col_reg, scan_col_next;
    logic [PW-1:0] look_row_reg, look_row_next;
    logic [PW-1:0] look_col_reg, look_col_next;
    logic [PW-1:0] a_row_reg, a_row_next;
    logic [PW-1:0] a_col_reg, a_col_next;
    logic [PW-1:0] b_row_reg, b_row_next;
    logic [PW-1:0] b_col_reg, b_col_next;
    logic [AW-1:0] o2_addr_reg, o2_addr_next;
    logic [IW-1:0] let1_reg, let1_next;
    logic [IW-1:0] let2_reg, let2_next;
    logic [IW-1:0] out_letter_reg, out_letter_next;
    logic          out_last_reg, out_last_next;

    // Grid RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [IW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [IW-1:0] ram_rdata;

    pfc_pkg::letter_t in_letter;
    logic             out_free;
    logic [AW-1:0]    o1_addr;
    logic [AW-1:0]    o2_addr;

    pfc_ram #(
        .WIDTH (pfc_pkg::IDX_W),
        .DEPTH (pfc_pkg::GRID_CELLS)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_letter = pfc_pkg::letter_index(data_byte);
    assign out_free  = !out_valid_reg || !out_stall;

    // Output cells of the pair from the located positions
    always_comb
    begin
        if (a_col_reg == b_col_reg)
        begin
            o1_addr = pfc_pkg::grid_addr(pfc_pkg::step_pos(a_row_reg, decrypt_mode_reg),
                                         a_col_reg);
            o2_addr = pfc_pkg::grid_addr(pfc_pkg::step_pos(b_row_reg, decrypt_mode_reg),
                                         b_col_reg);
        end
        else if (a_row_reg == b_row_reg)
        begin
            o1_addr = pfc_pkg::grid_addr(a_row_reg,
                                         pfc_pkg::step_pos(a_col_reg, decrypt_mode_reg));
            o2_addr = pfc_pkg::grid_addr(b_row_reg,
                                         pfc_pkg::step_pos(b_col_reg, decrypt_mode_reg));
        end
        else
        begin
            o1_addr = pfc_pkg::grid_addr(a_row_reg, b_col_reg);
            o2_addr = pfc_pkg::grid_addr(b_row_reg, a_col_reg);
        end
    end

    // Sequencer: next state, datapath updates and RAM control
    always_comb
    begin
        state_next          = state_reg;
        used_next           = used_reg;
        fill_count_next     = fill_count_reg;
        pending_valid_next  = pending_valid_reg;
        out_valid_next      = out_valid_reg;
        look_valid_next     = 1'b0;
        found_a_next        = found_a_reg;
        found_b_next        = found_b_reg;
        pending_letter_next = pending_letter_reg;
        pair_b_next         = pair_b_reg;
        fill_letter_next    = fill_letter_reg;
        scan_addr_next      = scan_addr_reg;
        scan_row_next       = scan_row_reg;
        scan_col_next       = scan_col_reg;
        look_row_next       = scan_row_reg;
        look_col_next       = scan_col_reg;
        a_row_next          = a_row_reg;
        a_col_next          = a_col_reg;
        b_row_next          = b_row_reg;
        b_col_next          = b_col_reg;
        o2_addr_next        = o2_addr_reg;
        let1_next           = let1_reg;
        let2_next           = let2_reg;
        out_letter_next     = out_letter_reg;
        out_last_next       = out_last_reg;
        ram_we              = 1'b0;
        ram_waddr           = fill_count_reg;
        ram_wdata           = in_letter.idx;
        ram_raddr           = scan_addr_reg;
        in_stall            = (state_reg != pfc_pkg::ST_IDLE);

        // Drop the output transaction once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Compare the cell read last cycle; keep the first match only
        if (look_valid_reg)
        begin
            if (!found_a_reg && ram_rdata == pending_letter_reg)
            begin
                found_a_next = 1'b1;
                a_row_next   = look_row_reg;
                a_col_next   = look_col_reg;
            end
            if (!found_b_reg && ram_rdata == pair_b_reg)
            begin
                found_b_next = 1'b1;
                b_row_next   = look_row_reg;
                b_col_next   = look_col_reg;
            end
        end

        case (state_reg)
            pfc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (operation)
                        pfc_pkg::OP_KEY_BYTE:
                        begin
                            if (in_letter.valid && fill_count_reg != pfc_pkg::CELLS_FULL
                                && !used_reg[in_letter.idx])
                            begin
                                ram_we                    = 1'b1;
                                used_next[in_letter.idx]  = 1'b1;
                                fill_count_next           = fill_count_reg + 5'd1;
                            end
                        end
                        pfc_pkg::OP_KEY_END:
                        begin
                            fill_letter_next = '0;
                            state_next       = pfc_pkg::ST_FILL;
                        end
                        pfc_pkg::OP_TEXT_BYTE:
                        begin
                            if (in_letter.valid)
                            begin
                                if (!pending_valid_reg)
                                begin
                                    pending_letter_next = in_letter.idx;
                                    pending_valid_next  = 1'b1;
                                end
                                else
                                begin
                                    pair_b_next = in_letter.idx;
                                    state_next  = pfc_pkg::ST_SCAN;
                                end
                            end
                        end
                        pfc_pkg::OP_TEXT_END:
                        begin
                            if (pending_valid_reg)
                            begin
                                pair_b_next = pfc_pkg::LETTER_X;
                                state_next  = pfc_pkg::ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = pfc_pkg::ST_IDLE;
                        end
                    endcase
                    // Start a pair scan from the first cell
                    if (state_next == pfc_pkg::ST_SCAN)
                    begin
                        pending_valid_next = 1'b0;
                        scan_addr_next     = '0;
                        scan_row_next      = '0;
                        scan_col_next      = '0;
                        found_a_next       = 1'b0;
                        found_b_next       = 1'b0;
                        a_row_next         = '0;
                        a_col_next         = '0;
                        b_row_next         = '0;
                        b_col_next         = '0;
                    end
                end
            end
            pfc_pkg::ST_FILL:
            begin
                ram_wdata = fill_letter_reg;
                if (fill_letter_reg != pfc_pkg::LETTER_J
                    && fill_count_reg != pfc_pkg::CELLS_FULL
                    && !used_reg[fill_letter_reg])
                begin
                    ram_we                     = 1'b1;
                    used_next[fill_letter_reg] = 1'b1;
                    fill_count_next            = fill_count_reg + 5'd1;
                end
                if (fill_letter_reg == pfc_pkg::LETTER_Z)
                begin
                    used_next       = '0;
                    fill_count_next = '0;
                    state_next      = pfc_pkg::ST_IDLE;
                end
                else
                begin
                    fill_letter_next = fill_letter_reg + 5'd1;
                end
            end
            pfc_pkg::ST_SCAN:
            begin
                look_valid_next = 1'b1;
                if (scan_addr_reg == pfc_pkg::ADDR_LAST)
                begin
                    state_next = pfc_pkg::ST_SCAN_END;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + 5'd1;
                    if (scan_col_reg == pfc_pkg::POS_LAST)
                    begin
                        scan_col_next = '0;
                        scan_row_next = scan_row_reg + 3'd1;
                    end
                    else
                    begin
                        scan_col_next = scan_col_reg + 3'd1;
                    end
                end
            end
            pfc_pkg::ST_SCAN_END:
            begin
                state_next = pfc_pkg::ST_READ1;
            end
            pfc_pkg::ST_READ1:
            begin
                ram_raddr    = o1_addr;
                o2_addr_next = o2_addr;
                state_next   = pfc_pkg::ST_READ2;
            end
            pfc_pkg::ST_READ2:
            begin
                ram_raddr  = o2_addr_reg;
                let1_next  = ram_rdata;
                state_next = pfc_pkg::ST_READ3;
            end
            pfc_pkg::ST_READ3:
            begin
                ram_raddr  = o2_addr_reg;
                let2_next  = ram_rdata;
                state_next = pfc_pkg::ST_EMIT1;
            end
            pfc_pkg::ST_EMIT1:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_letter_next = let1_reg;
                    out_last_next   = 1'b0;
                    state_next      = pfc_pkg::ST_EMIT2;
                end
            end
            pfc_pkg::ST_EMIT2:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_letter_next = let2_reg;
                    out_last_next   = 1'b1;
                    state_next      = pfc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfc_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= pfc_pkg::ST_IDLE;
            decrypt_mode_reg  <= 1'b0;
            used_reg          <= '0;
            fill_count_reg    <= '0;
            pending_valid_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
            look_valid_reg    <= 1'b0;
            found_a_reg       <= 1'b0;
            found_b_reg       <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            if (cfg_write_en)
            begin
                decrypt_mode_reg <= cfg_write_data;
            end
            used_reg          <= used_next;
            fill_count_reg    <= fill_count_next;
            pending_valid_reg <= pending_valid_next;
            out_valid_reg     <= out_valid_next;
            look_valid_reg    <= look_valid_next;
            found_a_reg       <= found_a_next;
            found_b_reg       <= found_b_next;
        end
    end

    // Hold payload state
    always_ff @(posedge clk)
    begin
        pending_letter_reg <= pending_letter_next;
        pair_b_reg         <= pair_b_next;
        fill_letter_reg    <= fill_letter_next;
        scan_addr_reg      <= scan_addr_next;
        scan_row_reg       <= scan_row_next;
        scan_col_reg       <= scan_col_next;
        look_row_reg       <= look_row_next;
        look_col_reg       <= look_col_next;
        a_row_reg          <= a_row_next;
        a_col_reg          <= a_col_next;
        b_row_reg          <= b_row_next;
        b_col_reg          <= b_col_next;
        o2_addr_reg        <= o2_addr_next;
        let1_reg           <= let1_next;
        let2_reg           <= let2_next;
        out_letter_reg     <= out_letter_next;
        out_last_reg       <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign letter      = pfc_pkg::ASCII_A + {2'b00, out_letter_reg};
    assign last_of_run = out_last_reg;

endmodule

// ===== design/pfc_checker.sv =====
`timescale 1ns / 1ps

module pfc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] operation,
    input logic       out_valid,
    input logic       out_stall,
    input logic [6:0] letter,
    input logic       last_of_run
);

    // A stalled result transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(letter) && $stable(last_of_run))
    else $error("stalled output payload changed");

    // The second letter of a pair follows right after the first is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid && last_of_run)
    else $error("second letter of pair missing");

    // No input is taken while half a pair is still out
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> in_stall)
    else $error("input accepted during a pair");

    // Key transactions never start a result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall
        && (operation == pfc_pkg::OP_KEY_BYTE || operation == pfc_pkg::OP_KEY_END)
        |=> !$rose(out_valid))
    else $error("key transaction produced a result");

endmodule

bind playfair_digraph_cipher_core pfc_checker u_pfc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .letter         (letter),
    .last_of_run    (last_of_run)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;
    localparam int   DIRECTED_ROWS = 25;
    localparam int   ITEM_TARGET   = 1100;
    localparam int   CALM_FROM     = 950;
    localparam int   SETTLE_CYCLES = 40;
    localparam int   STUCK_LIMIT   = 2000;

    typedef struct packed {
        logic [6:0] letter;
        logic       last;
    } cipher_letter_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       typed;
        logic [6:0] first;
        logic [6:0] second;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write_en = 1'b0;
    logic       cfg_write_data = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] operation = pfc_pkg::OP_KEY_BYTE;
    logic [7:0] data_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [6:0] letter;
    logic       last_of_run;

    // Predictor state: grid, key progress, held text letter, mode
    logic [pfc_pkg::IDX_W-1:0]    key_grid [pfc_pkg::GRID_CELLS];
    logic [pfc_pkg::ALPHABET-1:0] key_used = '0;
    int                           key_fill = 0;
    logic [pfc_pkg::IDX_W-1:0]    held_letter = '0;
    logic                         held_valid = 1'b0;
    logic                         cipher_mode = MODE_ENCRYPT;

    cipher_letter_t   expected_letters [$];
    stim_row_t        directed_rows [DIRECTED_ROWS];

    int  errors = 0;
    int  items_accepted = 0;
    int  letters_checked = 0;
    int  mode_writes = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  gaps_on = 1'b1;
    bit  stalls_on = 1'b1;
    bit  calm = 1'b0;

    playfair_digraph_cipher_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .letter         (letter),
        .last_of_run    (last_of_run)
    );

    always #5 clk = ~clk;

    // Find the first cell holding a letter; a missing letter sits at the origin
    function automatic int cell_of(input logic [pfc_pkg::IDX_W-1:0] l);
        for (int k = 0; k < pfc_pkg::GRID_CELLS; k++)
        begin
            if (key_grid[k] == l)
            begin
                return k;
            end
        end
        return 0;
    endfunction

    // Place a key letter in the next free cell unless used or grid full
    task automatic key_place(input logic [pfc_pkg::IDX_W-1:0] l);
        if (key_fill < pfc_pkg::GRID_CELLS && !key_used[l])
        begin
            key_grid[key_fill] = l;
            key_used[l] = 1'b1;
            key_fill++;
        end
    endtask

    // Encipher or decipher one pair of letters
    task automatic cipher_pair(input logic [pfc_pkg::IDX_W-1:0] a,
                               input logic [pfc_pkg::IDX_W-1:0] b,
                               output cipher_letter_t first, output cipher_letter_t second);
        int pa, pb, r1, c1, r2, c2, step, o1, o2;
        pa = cell_of(a);
        pb = cell_of(b);
        r1 = pa / pfc_pkg::GRID_SIDE;
        c1 = pa % pfc_pkg::GRID_SIDE;
        r2 = pb / pfc_pkg::GRID_SIDE;
        c2 = pb % pfc_pkg::GRID_SIDE;
        step = (cipher_mode == MODE_DECRYPT) ? pfc_pkg::GRID_SIDE - 1 : 1;
        if (c1 == c2)
        begin
            o1 = ((r1 + step) % pfc_pkg::GRID_SIDE) * pfc_pkg::GRID_SIDE + c1;
            o2 = ((r2 + step) % pfc_pkg::GRID_SIDE) * pfc_pkg::GRID_SIDE + c2;
        end
        else if (r1 == r2)
        begin
            o1 = r1 * pfc_pkg::GRID_SIDE + (c1 + step) % pfc_pkg::GRID_SIDE;
            o2 = r2 * pfc_pkg::GRID_SIDE + (c2 + step) % pfc_pkg::GRID_SIDE;
        end
        else
        begin
            o1 = r1 * pfc_pkg::GRID_SIDE + c2;
            o2 = r2 * pfc_pkg::GRID_SIDE + c1;
        end
        first.letter  = pfc_pkg::ASCII_A + {2'b00, key_grid[o1]};
        first.last    = 1'b0;
        second.letter = pfc_pkg::ASCII_A + {2'b00, key_grid[o2]};
        second.last   = 1'b1;
    endtask

    // Advance the cipher state by one input transaction; return 0 or 2 letters
    task automatic cipher_predict(input logic [1:0] op, input logic [7:0] b, output int n,
                                  output cipher_letter_t first, output cipher_letter_t second);
        logic                      is_letter;
        logic [pfc_pkg::IDX_W-1:0] idx;
        n = 0;
        first = '0;
        second = '0;
        is_letter = 1'b1;
        idx = '0;
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            idx = 5'(b - 8'h41);
        end
        else if (b >= 8'h61 && b <= 8'h7A)
        begin
            idx = 5'(b - 8'h61);
        end
        else
        begin
            is_letter = 1'b0;
        end
        if (idx == pfc_pkg::LETTER_J)
        begin
            idx = pfc_pkg::LETTER_I;
        end
        case (op)
            pfc_pkg::OP_KEY_BYTE:
            begin
                if (is_letter)
                begin
                    key_place(idx);
                end
            end
            pfc_pkg::OP_KEY_END:
            begin
                for (int c = 0; c < pfc_pkg::ALPHABET; c++)
                begin
                    if (5'(c) != pfc_pkg::LETTER_J)
                    begin
                        key_place(5'(c));
                    end
                end
                key_used = '0;
                key_fill = 0;
            end
            pfc_pkg::OP_TEXT_BYTE:
            begin
                if (is_letter)
                begin
                    if (!held_valid)
                    begin
                        held_letter = idx;
                        held_valid = 1'b1;
                    end
                    else
                    begin
                        cipher_pair(held_letter, idx, first, second);
                        n = 2;
                        held_valid = 1'b0;
                        held_letter = '0;
                    end
                end
            end
            default:
            begin
                if (held_valid)
                begin
                    cipher_pair(held_letter, pfc_pkg::LETTER_X, first, second);
                    n = 2;
                    held_valid = 1'b0;
                    held_letter = '0;
                end
            end
        endcase
    endtask

    // Drive one transaction, wait for acceptance, then queue its letters
    task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic typed,
                             input logic [6:0] t0, input logic [6:0] t1);
        int             gap, n;
        cipher_letter_t first, second;
        @(negedge clk);
        if (gaps_on && !calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        data_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        items_accepted++;
        cipher_predict(op, b, n, first, second);
        if (n == 2)
        begin
            if (typed)
            begin
                first.letter = t0;
                second.letter = t1;
            end
            expected_letters = {expected_letters, first, second};
        end
    endtask

    // Drain, let the block settle, then change the mode
    task automatic write_mode(input logic m);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_letters.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= m;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        cipher_mode = m;
        mode_writes++;
    endtask

    function automatic logic [7:0] random_letter_byte();
        logic [7:0] l;
        l = 8'($urandom_range(0, pfc_pkg::ALPHABET - 1));
        return ($urandom_range(0, 1) == 1) ? 8'h41 + l : 8'h61 + l;
    endfunction

    // Mostly letters, sometimes any byte at all
    function automatic logic [7:0] random_byte();
        if ($urandom_range(0, 9) < 8)
        begin
            return random_letter_byte();
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // One key (maybe) followed by one run of text, with some noise mixed in
    task automatic run_session();
        logic [7:0] alpha [pfc_pkg::ALPHABET];
        logic [7:0] tmp;
        int         len, j;
        if ($urandom_range(0, 3) != 0)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                // Whole alphabet shuffled plus extras: the grid overflows
                for (int k = 0; k < pfc_pkg::ALPHABET; k++)
                begin
                    alpha[k] = ($urandom_range(0, 1) == 1) ? 8'h41 + 8'(k) : 8'h61 + 8'(k);
                end
                for (int k = pfc_pkg::ALPHABET - 1; k > 0; k--)
                begin
                    j = $urandom_range(0, k);
                    tmp = alpha[k];
                    alpha[k] = alpha[j];
                    alpha[j] = tmp;
                end
                for (int k = 0; k < pfc_pkg::ALPHABET; k++)
                begin
                    send_item(pfc_pkg::OP_KEY_BYTE, alpha[k], 1'b0, '0, '0);
                end
                repeat ($urandom_range(1, 3)) send_item(pfc_pkg::OP_KEY_BYTE,
                                                        random_letter_byte(),
                                                        1'b0, '0, '0);
            end
            else
            begin
                len = $urandom_range(0, 12);
                repeat (len) send_item(pfc_pkg::OP_KEY_BYTE, random_byte(), 1'b0, '0, '0);
            end
            // Occasionally leave the key half written over the old grid
            if ($urandom_range(0, 7) != 0)
            begin
                send_item(pfc_pkg::OP_KEY_END, 8'($urandom_range(0, 255)), 1'b0, '0, '0);
            end
        end
        len = $urandom_range(0, 30);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0, '0, '0);
            end
            else
            begin
                send_item(pfc_pkg::OP_TEXT_BYTE, random_byte(), 1'b0, '0, '0);
            end
        end
        if ($urandom_range(0, 1) == 1)
        begin
            send_item(pfc_pkg::OP_TEXT_END, 8'($urandom_range(0, 255)), 1'b0, '0, '0);
        end
    endtask

    // Receiver stalls in random bursts
    always @(negedge clk)
    begin
        if (stall_left == 0 && stalls_on && !calm && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(1, 13);
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Check each accepted letter against the oldest expectation; watch for hangs
    always @(posedge clk)
    begin
        cipher_letter_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                letters_checked++;
                if (expected_letters.size() == 0)
                begin
                    $error("unexpected result transaction: letter %0h last_of_run %0b",
                           letter, last_of_run);
                    errors++;
                end
                else
                begin
                    want = expected_letters.pop_front();
                    if (letter !== want.letter)
                    begin
                        $error("letter mismatch: expected %0h actual %0h", want.letter, letter);
                        errors++;
                    end
                    if (last_of_run !== want.last)
                    begin
                        $error("last_of_run mismatch: expected %0b actual %0b",
                               want.last, last_of_run);
                        errors++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STUCK_LIMIT)
                begin
                    $display("Timeout: no transaction for %0d cycles, %0d letters pending",
                             STUCK_LIMIT, expected_letters.size());
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int  session;
        logic next_mode;
        session = 0;
        next_mode = MODE_DECRYPT;
        for (int k = 0; k < pfc_pkg::GRID_CELLS; k++)
        begin
            key_grid[k] = '0;
        end

        // Directed rows, encrypt mode; the first key end builds the plain a..z grid
        directed_rows = '{
            '{pfc_pkg::OP_KEY_END,   8'h00, 1'b0, 7'h00, 7'h00},
            '{pfc_pkg::OP_TEXT_BYTE, "a",   1'b0, 7'h00, 7'h00},
            '{pfc_pkg::OP_TEXT_BYTE, "B",   1'b1, 7'h62, 7'h63},  // same row: b c
            '{pfc_pkg::OP_TEXT_BYTE, "e",   1'b0, 7'h00, 7'h00},
            '{pfc_pkg::OP_TEXT_BYTE, "z",   1'b1, 7'h6B, 7'h65},  // same column, wraps: k e
            '{pfc_pkg::OP_TEXT_BYTE, "J",   1'b0, 7'h00, 7'h00},  // j read as i
            '{pfc_pkg::OP_TEXT_BYTE, "x",   1'b1, 7'h68, 7'h79},  // rectangle: h y
            '{pfc_pkg::OP_TEXT_BYTE, 8'h00, 1'b0, 7'h00, 7'h00},
            '{pfc_pkg::OP_TEXT_BYTE, 8'hFF, 1'b0, 7'h00, 7'h00},
            '{pfc_pkg::OP_TEXT_BYTE, "z",   1'b0, 7'h00, 7'h00},
            '{pfc_pkg::OP_TEXT_BYTE, "A",   1'b1, 7'h76, 7'h65},  // opposite corners: v e
            '{pfc_pkg::OP_TEXT_BYTE, "q",   1'b0, 7'h00, 7'h00},
            '{pfc_pkg::OP_TEXT_END,  8'hFF, 1'b1, 7'h73, 7'h76},  // pad with x: s v
            '{pfc_pkg::OP_TEXT_END,  8'h00, 1'b0, 7'h00, 7'h00},  // nothing held
            '{pfc_pkg::OP_TEXT_BYTE, "m",   1'b0, 7'h00, 7'h00},
            '{pfc_pkg::OP_TEXT_BYTE, "m",   1'b1, 7'h72, 7'h72},  // doubled letter: r r
            '{pfc_pkg::OP_TEXT_BYTE, "k",   1'b0, 7'h00, 7'h00},
            '{pfc_pkg::OP_KEY_BYTE,  "Z",   1'b0, 7'h00, 7'h00},  // new key over old grid
            '{pfc_pkg::OP_KEY_BYTE,  8'h40, 1'b0, 7'h00, 7'h00},
            '{pfc_pkg::OP_KEY_BYTE,  8'h5B, 1'b0, 7'h00, 7'h00},
            '{pfc_pkg::OP_KEY_BYTE,  8'h60, 1'b0, 7'h00, 7'h00},
            '{pfc_pkg::OP_KEY_BYTE,  8'h7B, 1'b0, 7'h00, 7'h00},
            '{pfc_pkg::OP_TEXT_BYTE, "a",   1'b0, 7'h00, 7'h00},  // a missing from grid
            '{pfc_pkg::OP_KEY_BYTE,  "j",   1'b0, 7'h00, 7'h00},
            '{pfc_pkg::OP_KEY_END,   8'h80, 1'b0, 7'h00, 7'h00}
        };

        // Hold reset, then release between edges
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            send_item(directed_rows[r].op, directed_rows[r].data, directed_rows[r].typed,
                      directed_rows[r].first, directed_rows[r].second);
        end

        // Random sessions; flip the mode every few sessions so both settings recur
        while (items_accepted < ITEM_TARGET)
        begin
            if (session % 4 == 0)
            begin
                write_mode(next_mode);
                next_mode = ~next_mode;
            end
            gaps_on   = ($urandom_range(0, 4) != 0);
            stalls_on = ($urandom_range(0, 4) != 0);
            calm      = (items_accepted >= CALM_FROM);
            run_session();
            session++;
        end

        // Drain and let the block settle
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_letters.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d input transactions in %0d sessions, %0d mode writes,",
                 items_accepted, session, mode_writes);
        $display("and checked %0d result letters against the cipher predictor.",
                 letters_checked);
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/pfc_pkg.sv
design/pfc_ram.sv
design/playfair_digraph_cipher_core.sv
design/pfc_checker.sv
bench/tb.sv
